// ----- hdl/ldf_pkg.sv -----
// Lidar frame deframer package: frame layout constants, status codes,
// register indexes and the frame-end request passed from parser to emitter.
// No dependencies.
`default_nettype none

package ldf_pkg;

  localparam int FRAME_BYTES = 195;
  localparam int SUM_END     = 194;
  localparam int POINT_COUNT = 12;
  localparam int POINT_BYTES = 15;
  localparam int POINT_BASE  = 10;
  localparam int STAMP_BASE  = 190;
  localparam int STAMP_BYTES = 4;
  localparam int CMD_POS     = 5;
  localparam int HDR_POS     = 4;
  localparam int REC_BYTES   = STAMP_BYTES + POINT_BYTES;

  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] HDR_SUM   = 8'hA8;
  localparam logic [7:0] CMD_RESET = 8'h02;
  localparam logic [2:0] HDR_RUN   = 3'd4;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_COMMAND  = 2'd2
  } status_e;

  typedef enum logic {
    REG_CMD = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic       valid;
    logic [1:0] channel;
    status_e    status;
  } emit_req_t;

endpackage

`default_nettype wire

// ----- hdl/ldf_if.sv -----
// Byte input and result output channel interfaces of the lidar frame deframer.
// Valid/ready handshake; payload widths are fixed by the frame format.
`default_nettype none

interface ldf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] sensor_id;
  logic [7:0] data_byte;

  modport source (output valid, sensor_id, data_byte, input ready);
  modport sink   (input valid, sensor_id, data_byte, output ready);
endinterface

interface ldf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic [1:0]         status;
  logic [3:0]         point_index;
  logic signed [15:0] distance;
  logic [15:0]        noise;
  logic [31:0]        peak;
  logic [7:0]         confidence;
  logic [31:0]        integration;
  logic signed [15:0] ref_tof;
  logic [31:0]        timestamp;
  logic               last;

  modport source (output valid, channel, status, point_index, distance, noise, peak,
                  confidence, integration, ref_tof, timestamp, last, input ready);
  modport sink   (input valid, channel, status, point_index, distance, noise, peak,
                  confidence, integration, ref_tof, timestamp, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/ldf_apb_regs.sv -----
// APB configuration register of the lidar frame deframer (expected command byte).
// Depends on ldf_pkg.
`default_nettype none

module ldf_apb_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       cmd_o
);
  import ldf_pkg::*;

  logic [7:0] cmd_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CMD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_RESET;
    end else if (wr_en) begin
      cmd_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_CMD) ? {24'd0, cmd_q} : 32'd0;
  assign cmd_o  = cmd_q;

endmodule

`default_nettype wire

// ----- hdl/ldf_frame_ram.sv -----
// Frame byte store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module ldf_frame_ram #(
  parameter int DEPTH  = 780,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/ldf_chan_parser.sv -----
// Per-channel header hunt and frame collection. Channel state lives in a
// synchronous memory updated read-modify-write; writes frame bytes to the store.
// Depends on ldf_pkg and ldf_if.
`default_nettype none

module ldf_chan_parser #(
  parameter int CHANNELS = 4,
  parameter int CH_W     = 2,
  parameter int ADDR_W   = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ldf_in_if.sink                 in_i,
  input  wire logic [7:0]        cmd_i,
  input  wire logic              emit_busy_i,
  output logic                   ram_we_o,
  output logic [ADDR_W-1:0]      ram_waddr_o,
  output logic [7:0]             ram_wdata_o,
  output ldf_pkg::emit_req_t     req_o
);
  import ldf_pkg::*;

  typedef enum logic [1:0] {
    P_IDLE = 2'b01,
    P_MOD  = 2'b10
  } pstate_e;

  typedef struct packed {
    logic [7:0] pos;
    logic [2:0] run;
    logic [7:0] sum;
    logic [7:0] cmd;
  } chan_state_t;

  chan_state_t state_mem [CHANNELS];
  chan_state_t rd_q;
  chan_state_t cur;
  chan_state_t nxt;

  pstate_e       state_q, state_d;
  logic [CHANNELS-1:0] valid_q;
  logic [1:0]    ch_q;
  logic [7:0]    byte_q;
  logic [CH_W-1:0] idx_q;
  logic          accept;
  logic          ch_ok;
  logic          take;
  logic          wb_en;
  logic [2:0]    run1;
  logic [7:0]    sum_body;
  logic          we;
  emit_req_t     req;

  assign in_i.ready = (state_q == P_IDLE) && !emit_busy_i;
  assign accept     = in_i.valid && in_i.ready;
  assign ch_ok      = 5'(in_i.sensor_id) < 5'(CHANNELS);
  assign take       = accept && ch_ok;
  assign wb_en      = (state_q == P_MOD);
  assign idx_q      = CH_W'(ch_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q   <= state_mem[CH_W'(in_i.sensor_id)];
      ch_q   <= in_i.sensor_id;
      byte_q <= in_i.data_byte;
    end
    if (wb_en) begin
      state_mem[idx_q] <= nxt;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      P_IDLE:  if (take) state_d = P_MOD;
      P_MOD:   state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (wb_en) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  assign cur      = valid_q[idx_q] ? rd_q : '0;
  assign run1     = cur.run + 3'd1;
  assign sum_body = cur.sum - HDR_SUM;

  always_comb begin
    nxt         = cur;
    we          = 1'b0;
    req.valid   = 1'b0;
    req.channel = ch_q;
    req.status  = ST_GOOD;
    if (cur.pos == 8'd0) begin
      if (byte_q == HDR_BYTE) begin
        if (run1 >= HDR_RUN) begin
          nxt.pos = 8'(HDR_POS);
          nxt.run = '0;
          nxt.sum = HDR_SUM;
        end else begin
          nxt.run = run1;
        end
      end else begin
        nxt.run = '0;
      end
    end else if (cur.pos >= 8'(FRAME_BYTES)) begin
      nxt.pos = '0;
      nxt.run = '0;
    end else begin
      we = 1'b1;
      if (cur.pos == 8'(CMD_POS)) begin
        nxt.cmd = byte_q;
      end
      if (cur.pos < 8'(SUM_END)) begin
        nxt.sum = cur.sum + byte_q;
        nxt.pos = cur.pos + 8'd1;
      end else begin
        nxt.pos   = '0;
        nxt.run   = '0;
        req.valid = 1'b1;
        if (cur.cmd != cmd_i) begin
          req.status = ST_COMMAND;
        end else if ((cur.sum != byte_q) && (sum_body != byte_q)) begin
          req.status = ST_CHECKSUM;
        end else begin
          req.status = ST_GOOD;
        end
      end
    end
  end

  assign ram_we_o    = we && wb_en;
  assign ram_waddr_o = ADDR_W'(ch_q) * ADDR_W'(FRAME_BYTES) + ADDR_W'(cur.pos);
  assign ram_wdata_o = byte_q;

  always_comb begin
    req_o       = req;
    req_o.valid = req.valid && wb_en;
  end

`ifndef SYNTHESIS
  a_mod_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == P_MOD))
    else $error("accepted byte not followed by state update");

  a_mod_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == P_MOD) |=> (state_q == P_IDLE))
    else $error("state update longer than one cycle");

  a_store_needs_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> valid_q[idx_q])
    else $error("frame byte written for channel with no frame state");
`endif

endmodule

`default_nettype wire

// ----- hdl/ldf_emitter.sv -----
// Frame-end result emitter: reads timestamp and point bytes from the frame
// store, assembles point records or a bad-frame status result and holds
// them in the output register. Depends on ldf_pkg and ldf_if.
`default_nettype none

module ldf_emitter #(
  parameter int ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  ldf_pkg::emit_req_t     req_i,
  output logic                   busy_o,
  output logic                   ram_re_o,
  output logic [ADDR_W-1:0]      ram_raddr_o,
  input  wire logic [7:0]        ram_rdata_i,
  ldf_out_if.source              out_o
);
  import ldf_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_READ = 4'b0010,
    E_WAIT = 4'b0100,
    E_LOAD = 4'b1000
  } estate_e;

  estate_e    state_q;
  logic [1:0] ch_q;
  status_e    status_q;
  logic [4:0] slot_q;
  logic [3:0] pt_q;
  logic [7:0] pbase_q;
  logic       rd_pend_q;
  logic [4:0] rd_slot_q;
  logic [7:0] rec_q [REC_BYTES];
  logic       out_valid_q;
  logic [7:0] offset;
  logic       out_free;
  logic       load;
  logic       bad;
  logic       last_pt;

  logic [1:0]         o_channel_q;
  logic [1:0]         o_status_q;
  logic [3:0]         o_index_q;
  logic signed [15:0] o_distance_q;
  logic [15:0]        o_noise_q;
  logic [31:0]        o_peak_q;
  logic [7:0]         o_conf_q;
  logic [31:0]        o_integ_q;
  logic signed [15:0] o_ref_q;
  logic [31:0]        o_stamp_q;
  logic               o_last_q;

  assign busy_o   = (state_q != E_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign load     = (state_q == E_LOAD) && out_free;
  assign bad      = (status_q != ST_GOOD);
  assign last_pt  = (pt_q == 4'(POINT_COUNT - 1));

  assign offset = (slot_q < 5'(STAMP_BYTES)) ? (8'(STAMP_BASE) + 8'(slot_q))
                                             : (pbase_q + 8'(slot_q) - 8'(STAMP_BYTES));
  assign ram_re_o    = (state_q == E_READ);
  assign ram_raddr_o = ADDR_W'(ch_q) * ADDR_W'(FRAME_BYTES) + ADDR_W'(offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      ch_q        <= '0;
      status_q    <= ST_GOOD;
      slot_q      <= '0;
      pt_q        <= '0;
      pbase_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_slot_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= ram_re_o;
      rd_slot_q <= slot_q;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        E_IDLE: begin
          if (req_i.valid) begin
            ch_q     <= req_i.channel;
            status_q <= req_i.status;
            slot_q   <= '0;
            pt_q     <= '0;
            pbase_q  <= 8'(POINT_BASE);
            state_q  <= (req_i.status == ST_GOOD) ? E_READ : E_LOAD;
          end
        end
        E_READ: begin
          slot_q <= slot_q + 5'd1;
          if (slot_q == 5'(REC_BYTES - 1)) begin
            state_q <= E_WAIT;
          end
        end
        E_WAIT: state_q <= E_LOAD;
        E_LOAD: begin
          if (out_free) begin
            if (bad || last_pt) begin
              state_q <= E_IDLE;
            end else begin
              pt_q    <= pt_q + 4'd1;
              pbase_q <= pbase_q + 8'(POINT_BYTES);
              slot_q  <= 5'(STAMP_BYTES);
              state_q <= E_READ;
            end
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      rec_q[rd_slot_q] <= ram_rdata_i;
    end
    if (load) begin
      o_channel_q <= ch_q;
      o_status_q  <= status_q;
      o_last_q    <= bad || last_pt;
      if (bad) begin
        o_index_q    <= '0;
        o_distance_q <= '0;
        o_noise_q    <= '0;
        o_peak_q     <= '0;
        o_conf_q     <= '0;
        o_integ_q    <= '0;
        o_ref_q      <= '0;
        o_stamp_q    <= '0;
      end else begin
        o_index_q    <= pt_q;
        o_distance_q <= $signed({rec_q[5], rec_q[4]});
        o_noise_q    <= {rec_q[7], rec_q[6]};
        o_peak_q     <= {rec_q[11], rec_q[10], rec_q[9], rec_q[8]};
        o_conf_q     <= rec_q[12];
        o_integ_q    <= {rec_q[16], rec_q[15], rec_q[14], rec_q[13]};
        o_ref_q      <= $signed({rec_q[18], rec_q[17]});
        o_stamp_q    <= {rec_q[3], rec_q[2], rec_q[1], rec_q[0]};
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.channel     = o_channel_q;
  assign out_o.status      = o_status_q;
  assign out_o.point_index = o_index_q;
  assign out_o.distance    = o_distance_q;
  assign out_o.noise       = o_noise_q;
  assign out_o.peak        = o_peak_q;
  assign out_o.confidence  = o_conf_q;
  assign out_o.integration = o_integ_q;
  assign out_o.ref_tof     = o_ref_q;
  assign out_o.timestamp   = o_stamp_q;
  assign out_o.last        = o_last_q;

`ifndef SYNTHESIS
  a_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> (state_q == E_IDLE))
    else $error("frame-end request while emitter busy");

  a_load_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_LOAD) |-> !rd_pend_q)
    else $error("record loaded with store read outstanding");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_o.status != ST_GOOD)) |-> out_o.last)
    else $error("status result without last flag");
`endif

endmodule

`default_nettype wire

// ----- hdl/lidar_frame_deframer.sv -----
// Lidar frame deframer top level: APB register, channel parser, frame store
// and result emitter. Depends on ldf_pkg, ldf_if and the ldf_* modules.
//
// Usage: bytes tagged with a sensor channel enter on in_i; a byte on a
// channel number at or above CHANNELS is accepted and dropped. Each byte on a
// valid channel is accepted and then written back by a read-modify-write of the
// channel-state memory; in_i.ready is low during the write-back.
// At the checksum byte of a frame one result or a run of twelve is emitted on
// out_o. A bad frame gives one status result, loaded when the output is free.
// A good frame reads 184 bytes from the frame store: the timestamp and the
// first point, then each further point, each record loaded when the output
// is free; in_i.ready stays low until the last point is loaded.
// out_o is a registered stage: the block takes new bytes while the final
// result waits; a stalled receiver holds the emitter at the next record.
// The expected command byte is written over APB at address 0 (reset 0x02).
// Reset sets every channel hunting for a header; the frame store needs no
// clearing pass, channel state uses per-channel valid bits.
`default_nettype none

module lidar_frame_deframer #(
  parameter int CHANNELS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ldf_in_if.sink           in_i,
  ldf_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ldf_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        cmd;
  logic              emit_busy;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  emit_req_t         req;

  ldf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_o   (cmd)
  );

  ldf_chan_parser #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W),
    .ADDR_W   (ADDR_W)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .emit_busy_i (emit_busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .req_o       (req)
  );

  ldf_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ldf_emitter #(
    .ADDR_W (ADDR_W)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .busy_o      (emit_busy),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
